@@ design/tlc_pkg.sv @@
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, widths and codes for the track lifecycle confirmer.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int COUNT_BITS = 8;
    localparam int TIMER_BITS = 16;

    localparam int NEEDED_BITS = 8;
    localparam int TIMEOUT_BITS = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;

    // Wide enough to compare a count or a timeout of any allowed width.
    localparam int CMP_BITS = 33;

    localparam logic [CMP_BITS-1:0] TIMER_MAX_W =
        (CMP_BITS'(1) << TIMER_BITS) - CMP_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDED_SIGHTINGS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOSE_TIMEOUT     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOCK_TIMEOUT     = 2'd2;

    localparam logic [NEEDED_BITS-1:0]  NEEDED_RESET = 8'd3;
    localparam logic [TIMEOUT_BITS-1:0] LOSE_RESET   = 16'd30;
    localparam logic [TIMEOUT_BITS-1:0] LOCK_RESET   = 16'd30;

    // Operation codes.
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SIGHTING = 1'b1;

    // Lifecycle codes.
    localparam logic [1:0] LC_HYPO    = 2'd0;
    localparam logic [1:0] LC_TRACKED = 2'd1;
    localparam logic [1:0] LC_LOST    = 2'd2;

    // Event codes.
    localparam logic [1:0] EV_NONE        = 2'd0;
    localparam logic [1:0] EV_NEW_OBJECT  = 2'd1;
    localparam logic [1:0] EV_DISAPPEARED = 2'd2;
    localparam logic [1:0] EV_REAPPEARED  = 2'd3;

    typedef struct packed {
        logic opcode;
        logic inconsistent_flag;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_code;
        logic       delete_request;
        logic [1:0] lifecycle_state;
    } t_out_item;

    // A timeout register larger than the timer saturates at the timer's maximum.
    function automatic logic [TIMER_BITS-1:0] clamp_timer(
        input logic [TIMEOUT_BITS-1:0] v
    );
        logic [CMP_BITS-1:0] wide;
        wide = CMP_BITS'(v);
        if (wide > TIMER_MAX_W) begin
            return TIMER_MAX_W[TIMER_BITS-1:0];
        end
        return wide[TIMER_BITS-1:0];
    endfunction

endpackage

@@ design/track_lifecycle_confirmer_unit.sv @@
// ----------------------------------------------------------------------------
// track_lifecycle_confirmer_unit
// M-of-N confirmation and deletion of one tracked object.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer carries either a sighting of the object or a tick of
// time, with a flag that forces a tracked object to be lost on a tick. Every
// input transfer produces exactly one output transfer with the event code,
// the sticky delete request and the lifecycle state after that item.
// The state update happens in the cycle of the input transfer and the result
// sits in an output register, so one item can be taken every cycle while
// the receiver takes results. The result register is the only storage
// between the two sides: input ready stays high while the result register
// is empty or being drained in the same cycle. When the receiver stalls,
// the held result blocks further input until it is taken.
// Configuration is a plain write port (enable, index, data) and is meant to
// be written only while no transfer is in flight.
// Reset is synchronous and active low: the object returns to hypothetical
// with zero count, zero countdown and no delete mark, the registers return
// to three sightings and timeouts of 30 ticks, and the result register empties.
// ----------------------------------------------------------------------------
module track_lifecycle_confirmer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tlc_pkg::t_in_item                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tlc_pkg::t_out_item                o_out,
    input  logic                              i_cfg_we,
    input  logic [tlc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [tlc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import tlc_pkg::*;

    logic [NEEDED_BITS-1:0]  r_needed;
    logic [TIMEOUT_BITS-1:0] r_lose_timeout;
    logic [TIMEOUT_BITS-1:0] r_lock_timeout;

    logic [1:0]            r_lifecycle, n_lifecycle;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [TIMER_BITS-1:0] r_countdown, n_countdown;
    logic                  r_delete, n_delete;
    logic [1:0]            n_event;

    logic      r_out_valid;
    t_out_item r_out;

    logic accept;
    logic count_met;
    logic [TIMER_BITS-1:0] loaded;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign count_met = CMP_BITS'(r_count) >= CMP_BITS'(r_needed);

    always_comb begin
        n_lifecycle = r_lifecycle;
        n_count     = r_count;
        n_countdown = r_countdown;
        n_delete    = r_delete;
        n_event     = EV_NONE;
        loaded      = r_countdown;
        if (i_in.opcode == OP_SIGHTING) begin
            if (r_lifecycle == LC_TRACKED) begin
                n_countdown = clamp_timer(r_lose_timeout);
            end else begin
                if (r_count == '0) begin
                    n_countdown = clamp_timer(r_lock_timeout);
                end
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + COUNT_BITS'(1);
                end
            end
        end else begin
            unique case (r_lifecycle)
                LC_TRACKED: begin
                    if (r_countdown == '0 || i_in.inconsistent_flag) begin
                        n_event     = EV_DISAPPEARED;
                        n_lifecycle = LC_LOST;
                        n_count     = '0;
                    end
                end
                LC_LOST: begin
                    if (count_met) begin
                        n_event     = EV_REAPPEARED;
                        n_lifecycle = LC_TRACKED;
                        loaded      = clamp_timer(r_lose_timeout);
                    end else if (r_countdown == '0) begin
                        n_count = '0;
                    end
                end
                default: begin
                    // Hypothetical, and any unused code treated the same way.
                    n_lifecycle = LC_HYPO;
                    if (count_met) begin
                        n_event     = EV_NEW_OBJECT;
                        n_lifecycle = LC_TRACKED;
                        loaded      = clamp_timer(r_lose_timeout);
                    end else if (r_countdown == '0) begin
                        n_delete = 1'b1;
                    end
                end
            endcase
            // The timer counts down after any reload on the same tick.
            n_countdown = (loaded != '0) ? loaded - TIMER_BITS'(1) : loaded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needed       <= NEEDED_RESET;
            r_lose_timeout <= LOSE_RESET;
            r_lock_timeout <= LOCK_RESET;
            r_lifecycle    <= LC_HYPO;
            r_count        <= '0;
            r_countdown    <= '0;
            r_delete       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_NEEDED_SIGHTINGS: r_needed <= i_cfg_data[NEEDED_BITS-1:0];
                    REG_LOSE_TIMEOUT:     r_lose_timeout <= i_cfg_data;
                    REG_LOCK_TIMEOUT:     r_lock_timeout <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_lifecycle <= n_lifecycle;
                r_count     <= n_count;
                r_countdown <= n_countdown;
                r_delete    <= n_delete;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.event_code      <= n_event;
            r_out.delete_request  <= n_delete;
            r_out.lifecycle_state <= n_lifecycle;
        end
    end

endmodule

@@ verif/track_lifecycle_confirmer_unit_test.sv @@
// ----------------------------------------------------------------------------
// track_lifecycle_confirmer_unit_test
// Self-checking bench for the track lifecycle confirmer. Sightings and ticks
// are sent as directed sequences and as random bursts under several register
// settings. An in-bench lifecycle predictor supplies the expected event,
// delete request and state for every transfer, and each result is checked in
// order. Both handshake sides idle at random, and one long receiver stall
// backs the block up.
// ----------------------------------------------------------------------------
module track_lifecycle_confirmer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tlc_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int HOLD_CYCLES = 120;
    localparam int QUIET_LIMIT = 2000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    t_in_item                  in_item = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    t_out_item                 out_item;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Predicted object state and register copies.
    logic [1:0]              track_phase = LC_HYPO;
    logic [COUNT_BITS-1:0]   sight_count = '0;
    logic [TIMER_BITS-1:0]   timer_left = '0;
    logic                    delete_flag = 1'b0;
    logic [NEEDED_BITS-1:0]  needed_cfg = NEEDED_RESET;
    logic [TIMEOUT_BITS-1:0] lose_cfg = LOSE_RESET;
    logic [TIMEOUT_BITS-1:0] lock_cfg = LOCK_RESET;

    t_out_item pending_reports[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    bit        idle_on = 1'b1;
    bit        holding = 1'b0;
    event      start_hold;

    track_lifecycle_confirmer_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // A timeout wider than the timer saturates when it is loaded.
    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [TIMEOUT_BITS-1:0] ticks);
        longint unsigned top;
        top = (64'd1 << TIMER_BITS) - 64'd1;
        if (64'(ticks) > top) begin
            return TIMER_BITS'(top);
        end
        return TIMER_BITS'(ticks);
    endfunction

    function automatic t_out_item advance_lifecycle(input t_in_item item);
        t_out_item  report;
        logic [1:0] ev;
        ev = EV_NONE;
        if (item.opcode == OP_SIGHTING) begin
            if (track_phase == LC_TRACKED) begin
                timer_left = timer_load(lose_cfg);
            end else begin
                if (sight_count == '0) begin
                    timer_left = timer_load(lock_cfg);
                end
                if (sight_count != COUNT_MAX) begin
                    sight_count = sight_count + COUNT_BITS'(1);
                end
            end
        end else begin
            case (track_phase)
                LC_TRACKED: begin
                    if (timer_left == '0 || item.inconsistent_flag) begin
                        ev = EV_DISAPPEARED;
                        track_phase = LC_LOST;
                        sight_count = '0;
                    end
                end
                LC_LOST: begin
                    if (sight_count >= needed_cfg) begin
                        ev = EV_REAPPEARED;
                        track_phase = LC_TRACKED;
                        timer_left = timer_load(lose_cfg);
                    end else if (timer_left == '0) begin
                        sight_count = '0;
                    end
                end
                default: begin
                    track_phase = LC_HYPO;
                    if (sight_count >= needed_cfg) begin
                        ev = EV_NEW_OBJECT;
                        track_phase = LC_TRACKED;
                        timer_left = timer_load(lose_cfg);
                    end else if (timer_left == '0) begin
                        delete_flag = 1'b1;
                    end
                end
            endcase
            if (timer_left != '0) begin
                timer_left = timer_left - TIMER_BITS'(1);
            end
        end
        report.event_code      = ev;
        report.delete_request  = delete_flag;
        report.lifecycle_state = track_phase;
        return report;
    endfunction

    // Result checking, prediction of accepted items, and the stall watchdog.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
                    mismatch_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (out_item.event_code !== want.event_code) begin
                        $display("%0t: event_code expected %0d actual %0d",
                                 $time, want.event_code, out_item.event_code);
                        mismatch_count++;
                    end
                    if (out_item.delete_request !== want.delete_request) begin
                        $display("%0t: delete_request expected %0d actual %0d",
                                 $time, want.delete_request, out_item.delete_request);
                        mismatch_count++;
                    end
                    if (out_item.lifecycle_state !== want.lifecycle_state) begin
                        $display("%0t: lifecycle_state expected %0d actual %0d",
                                 $time, want.lifecycle_state, out_item.lifecycle_state);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                pending_reports = {pending_reports, advance_lifecycle(in_item)};
            end
            if ((out_valid && out_ready) || (in_valid && in_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (holding) begin
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(99) < 27) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        forever begin
            @(start_hold);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding = 1'b0;
        end
    end

    // Valid is left high when the next item follows at once; callers that stop
    // sending lower it in the same step through wait_all_results.
    task automatic send_item(input logic op, input logic flag);
        in_item.opcode            <= op;
        in_item.inconsistent_flag <= flag;
        in_valid                  <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (idle_on && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_NEEDED_SIGHTINGS: needed_cfg = value[NEEDED_BITS-1:0];
            REG_LOSE_TIMEOUT:     lose_cfg = value[TIMEOUT_BITS-1:0];
            REG_LOCK_TIMEOUT:     lock_cfg = value[TIMEOUT_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input int needed, input int lose, input int lock);
        write_reg(REG_NEEDED_SIGHTINGS, CFG_DATA_BITS'(needed));
        write_reg(REG_LOSE_TIMEOUT, CFG_DATA_BITS'(lose));
        write_reg(REG_LOCK_TIMEOUT, CFG_DATA_BITS'(lock));
    endtask

    // Mostly runs of sightings followed by runs of ticks, with some noise.
    task automatic run_tracking_traffic(input int n_items, input int max_burst,
                                        input int max_ticks);
        int sent;
        int run_len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 20) begin
                send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end else begin
                run_len = $urandom_range(max_burst);
                repeat (run_len) send_item(OP_SIGHTING, 1'($urandom_range(1)));
                sent += run_len;
                run_len = $urandom_range(1, max_ticks);
                repeat (run_len) send_item(OP_TICK, $urandom_range(99) < 8);
                sent += run_len;
            end
        end
        wait_all_results();
    endtask

    task automatic test_hypothesis_deletion();
        write_reg(REG_LOCK_TIMEOUT, 16'd2);
        send_item(OP_SIGHTING, 1'b1);
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);
        // The lock window has run out with too few sightings.
        send_item(OP_TICK, 1'b0);
        send_item(OP_SIGHTING, 1'b0);
        send_item(OP_SIGHTING, 1'b0);
        send_item(OP_TICK, 1'b0);
        wait_all_results();
    endtask

    task automatic test_loss_and_reacquire();
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b1);
        send_item(OP_SIGHTING, 1'b0);
        send_item(OP_SIGHTING, 1'b0);
        send_item(OP_SIGHTING, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_SIGHTING, 1'b0);
        send_item(OP_TICK, 1'b0);
        wait_all_results();
    endtask

    task automatic test_zero_threshold();
        set_config(0, 0, 65535);
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_SIGHTING, 1'b0);
        send_item(OP_TICK, 1'b0);
        wait_all_results();
    endtask

    task automatic test_lost_count_clear();
        set_config(255, 65535, 0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_SIGHTING, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_SIGHTING, 1'b0);
        wait_all_results();
    endtask

    task automatic test_random_configs();
        repeat (6) begin
            set_config($urandom_range(1, 6), $urandom_range(0, 24), $urandom_range(0, 24));
            run_tracking_traffic(130, 8, 30);
        end
    endtask

    task automatic test_without_idling();
        idle_on = 1'b0;
        set_config(2, 5, 5);
        run_tracking_traffic(250, 4, 8);
        idle_on = 1'b1;
    endtask

    task automatic test_count_saturation();
        set_config(255, 65535, 65535);
        run_tracking_traffic(300, 300, 3);
    endtask

    task automatic test_extreme_timeouts();
        set_config(1, 65535, 0);
        run_tracking_traffic(150, 3, 6);
        set_config(1, 0, 65535);
        run_tracking_traffic(150, 3, 6);
    endtask

    // The sender keeps offering while the receiver holds off, so the output
    // register fills and input ready drops.
    task automatic test_backpressure();
        set_config(3, 10, 10);
        -> start_hold;
        repeat (40) send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
        wait_all_results();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_hypothesis_deletion();
        test_loss_and_reacquire();
        test_zero_threshold();
        test_lost_count_clear();
        test_random_configs();
        test_without_idling();
        test_backpressure();
        test_count_saturation();
        test_extreme_timeouts();
        wait_all_results();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
